>>> src/carpid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package carpid_pkg;

	// sample and gain formats
	localparam int SAMPLE_W   = 16;
	localparam int GAIN_W     = 24;
	localparam int GFB        = 12;
	localparam int LIM_W      = 16;
	localparam int OLIM_W     = 15;
	localparam int DRIVE_W    = 16;
	localparam int ESUM_W     = 18;

	// serial multiplier: gain consumed one digit per cycle
	localparam int DIGIT_W    = 4;
	localparam int DIGITS     = GAIN_W / DIGIT_W;
	localparam int CNT_W      = $clog2(DIGITS);

	// accumulator holds the inner loop sum at 2*GFB fraction bits
	localparam int ACC_W      = 70;
	localparam int MAG_W      = ACC_W - 2 * GFB;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	typedef logic signed [ACC_W-1:0]    acc_t;
	typedef logic signed [SAMPLE_W:0]   diff_t;
	typedef logic signed [ESUM_W-1:0]   esum_t;

	typedef struct packed {
		logic load;
		logic clear_acc;
	} mac_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL,
		ST_NEG,
		ST_SAT
	} state_t;

	typedef enum logic [2:0] {
		OP_KP,
		OP_KI,
		OP_KD,
		OP_IKP,
		OP_IKD
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OUTER_KP       = 3'd0,
		REG_OUTER_KI       = 3'd1,
		REG_OUTER_KD       = 3'd2,
		REG_INNER_KP       = 3'd3,
		REG_INNER_KD       = 3'd4,
		REG_INTEGRAL_LIMIT = 3'd5,
		REG_OUTPUT_LIMIT   = 3'd6
	} cfg_reg_t;

endpackage
`default_nettype wire

>>> src/carpid_mac.sv
`timescale 1ns / 1ps
`default_nettype none
module carpid_mac
	import carpid_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire mac_ctrl_t             ctrl,
	input  wire acc_t                  mcand_in,
	input  wire logic [GAIN_W-1:0]     gain_in,
	output acc_t                       acc,
	output logic                       last
);

	acc_t                     mcand_q;
	acc_t                     acc_q;
	logic [GAIN_W-1:0]        gain_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     busy_q;
	logic signed [DIGIT_W:0]  digit;
	logic signed [ACC_W+DIGIT_W:0] prod;

	// partial product of the current gain digit
	assign digit = $signed({1'b0, gain_q[DIGIT_W-1:0]});
	assign prod  = (ACC_W+DIGIT_W+1)'(mcand_q) * (ACC_W+DIGIT_W+1)'(digit);

	assign acc  = acc_q;
	assign last = busy_q && (cnt_q == CNT_W'(DIGITS - 1));

	// digit counter and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctrl.load) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (last)
				busy_q <= 1'b0;
		end
	end

	// multiplicand shifts up, gain shifts down, one digit a cycle
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			mcand_q <= mcand_in;
			gain_q  <= gain_in;
			if (ctrl.clear_acc)
				acc_q <= '0;
		end else if (busy_q) begin
			acc_q   <= acc_q + prod[ACC_W-1:0];
			mcand_q <= mcand_q <<< DIGIT_W;
			gain_q  <= gain_q >> DIGIT_W;
		end
	end

endmodule
`default_nettype wire

>>> src/cascade_angle_rate_pid.sv
// Cascaded angle/rate controller with one shared digit-serial multiplier.
// Each item runs five 24-bit gain products in turn, each a load step
// followed by six 4-bit gain digits, then sign and clamp steps. A new
// item is taken only when idle, once the previous result is loaded out.
// arst_n (async, active low) restores the default gains and limits and
// clears the integral, the previous angle and rate, and the output valid flag.
`timescale 1ns / 1ps
`default_nettype none
module cascade_angle_rate_pid
	import carpid_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// target_angle [15:0], gyro_rate [31:16], measured_angle [47:32]
	input  wire logic [3*SAMPLE_W-1:0] s_axis_tdata,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// drive [15:0]
	output logic [DRIVE_W-1:0]         m_axis_tdata,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	state_t                    state_q, state_d;
	op_t                       op_q, op_d;
	logic [GAIN_W-1:0]         okp_q, oki_q, okd_q, ikp_q, ikd_q;
	logic [LIM_W-1:0]          ilim_q;
	logic [OLIM_W-1:0]         olim_q;
	esum_t                     esum_q;
	logic signed [SAMPLE_W-1:0] prev_angle_q, prev_rate_q, gyro_q;
	diff_t                     err_q, dang_q, drate_q;
	logic [MAG_W-1:0]          mag_q;
	logic                      neg_q;
	logic                      out_valid_q;
	logic [DRIVE_W-1:0]        out_drive_q;

	logic signed [SAMPLE_W-1:0] in_target, in_gyro, in_angle;
	diff_t                     err, dang, drate;
	logic signed [ESUM_W:0]    esum_raw, lim_s;
	esum_t                     esum_new;
	logic                      accept, out_load;
	mac_ctrl_t                 mac_ctrl;
	acc_t                      mac_mcand, mac_acc, gyro_term, acc_abs;
	logic [GAIN_W-1:0]         mac_gain;
	logic                      mac_last;
	logic                      over;
	logic [OLIM_W-1:0]         mag_sat;
	logic [DRIVE_W-1:0]        drive_val;

	assign in_target = s_axis_tdata[SAMPLE_W-1:0];
	assign in_gyro   = s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
	assign in_angle  = s_axis_tdata[3*SAMPLE_W-1:2*SAMPLE_W];

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_drive_q;

	// differences and clamped integral of the new sample
	assign err      = diff_t'(in_angle) - diff_t'(in_target);
	assign dang     = diff_t'(in_angle) - diff_t'(prev_angle_q);
	assign drate    = diff_t'(in_gyro) - diff_t'(prev_rate_q);
	assign esum_raw = (ESUM_W+1)'(esum_q) + (ESUM_W+1)'(err);
	assign lim_s    = $signed({{(ESUM_W+1-LIM_W){1'b0}}, ilim_q});

	always_comb begin
		if (esum_raw > lim_s)
			esum_new = ESUM_W'(lim_s);
		else if (esum_raw < -lim_s)
			esum_new = ESUM_W'(-lim_s);
		else
			esum_new = ESUM_W'(esum_raw);
	end

	// 3.5 * gyro at GFB fraction bits: (8 - 1) * 2^(GFB-1)
	assign gyro_term = (acc_t'(gyro_q) <<< (GFB + 2)) - (acc_t'(gyro_q) <<< (GFB - 1));

	// magnitude of the final sum and clamp to the output limit
	assign acc_abs   = mac_acc[ACC_W-1] ? -mac_acc : mac_acc;
	assign over      = (|mag_q[MAG_W-1:OLIM_W]) || (mag_q[OLIM_W-1:0] > olim_q);
	assign mag_sat   = over ? olim_q : mag_q[OLIM_W-1:0];
	assign drive_val = neg_q ? -DRIVE_W'(mag_sat) : DRIVE_W'(mag_sat);

	// operand select for the next product
	always_comb begin
		mac_mcand = '0;
		mac_gain  = '0;
		case (op_q)
			OP_KP: begin
				mac_mcand = acc_t'(err_q);
				mac_gain  = okp_q;
			end
			OP_KI: begin
				mac_mcand = acc_t'(esum_q);
				mac_gain  = oki_q;
			end
			OP_KD: begin
				mac_mcand = acc_t'(dang_q);
				mac_gain  = okd_q;
			end
			OP_IKP: begin
				mac_mcand = mac_acc + gyro_term;
				mac_gain  = ikp_q;
			end
			OP_IKD: begin
				mac_mcand = acc_t'(drate_q) <<< GFB;
				mac_gain  = ikd_q;
			end
			default: begin
				mac_mcand = '0;
				mac_gain  = '0;
			end
		endcase
	end

	// sequencer next state and strobes
	always_comb begin
		state_d            = state_q;
		op_d               = op_q;
		s_axis_tready      = 1'b0;
		mac_ctrl.load      = 1'b0;
		mac_ctrl.clear_acc = 1'b0;
		out_load           = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					op_d    = OP_KP;
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				mac_ctrl.load      = 1'b1;
				mac_ctrl.clear_acc = (op_q == OP_KP) || (op_q == OP_IKP);
				state_d            = ST_MUL;
			end
			ST_MUL: begin
				if (mac_last) begin
					case (op_q)
						OP_KP:   op_d = OP_KI;
						OP_KI:   op_d = OP_KD;
						OP_KD:   op_d = OP_IKP;
						OP_IKP:  op_d = OP_IKD;
						default: op_d = OP_KP;
					endcase
					state_d = (op_q == OP_IKD) ? ST_NEG : ST_LOAD;
				end
			end
			ST_NEG: begin
				state_d = ST_SAT;
			end
			ST_SAT: begin
				if (!out_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_KP;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			okp_q  <= GAIN_W'(1228800);
			oki_q  <= GAIN_W'(819);
			okd_q  <= GAIN_W'(1638400);
			ikp_q  <= GAIN_W'(40960);
			ikd_q  <= GAIN_W'(24576);
			ilim_q <= LIM_W'(1000);
			olim_q <= OLIM_W'(28000);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OUTER_KP:       okp_q  <= cfg_data[GAIN_W-1:0];
				REG_OUTER_KI:       oki_q  <= cfg_data[GAIN_W-1:0];
				REG_OUTER_KD:       okd_q  <= cfg_data[GAIN_W-1:0];
				REG_INNER_KP:       ikp_q  <= cfg_data[GAIN_W-1:0];
				REG_INNER_KD:       ikd_q  <= cfg_data[GAIN_W-1:0];
				REG_INTEGRAL_LIMIT: ilim_q <= cfg_data[LIM_W-1:0];
				REG_OUTPUT_LIMIT:   olim_q <= cfg_data[OLIM_W-1:0];
				default: ;
			endcase
		end
	end

	// loop state carried between items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esum_q       <= '0;
			prev_angle_q <= '0;
			prev_rate_q  <= '0;
		end else if (accept) begin
			esum_q       <= esum_new;
			prev_angle_q <= in_angle;
			prev_rate_q  <= in_gyro;
		end
	end

	// per-item operands and final magnitude
	always_ff @(posedge clk) begin
		if (accept) begin
			err_q   <= err;
			dang_q  <= dang;
			drate_q <= drate;
			gyro_q  <= in_gyro;
		end
		if (state_q == ST_NEG) begin
			mag_q <= acc_abs[ACC_W-1:2*GFB];
			neg_q <= mac_acc[ACC_W-1];
		end
	end

	// output slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load)
			out_drive_q <= drive_val;
	end

	carpid_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (mac_ctrl),
		.mcand_in (mac_mcand),
		.gain_in  (mac_gain),
		.acc      (mac_acc),
		.last     (mac_last)
	);

endmodule
`default_nettype wire

>>> src/carpid_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module carpid_port_checker
	import carpid_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_axis_tvalid,
	input wire logic                  s_axis_tready,
	input wire logic [DRIVE_W-1:0]    m_axis_tdata,
	input wire logic                  m_axis_tvalid,
	input wire logic                  m_axis_tready
);

	// busy straight after an item is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input ready right after an accepted item");

	// a new result appears only as the block finishes its item
	a_result_at_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> s_axis_tready && $past(!s_axis_tready))
		else $error("result appeared while not finishing an item");

	// saturation is symmetric, so the most negative code never shows
	a_drive_symmetric: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata != 16'h8000)
		else $error("drive outside symmetric range");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

endmodule

bind cascade_angle_rate_pid carpid_port_checker u_carpid_port_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready)
);
`default_nettype wire
